@@ rtl/tti_pkg.sv @@
// ----------------------------------------------------------------------------
// tti_pkg
// shared widths, constants and handshake structs of the thermistor table
// interpolator
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int COUNT_W       = 14;
    localparam int TEMP_W        = 14;
    localparam int ENTRY_W       = COUNT_W + TEMP_W;

    localparam int NUM_W         = 28;
    localparam int DEN_W         = 14;
    localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_TEMP = TEMP_W'(-800);
    localparam logic signed [TEMP_W-1:0] TEMP_MIN       = TEMP_W'(-8192);
    localparam logic signed [TEMP_W-1:0] TEMP_MAX       = TEMP_W'(8191);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/thermistor_table_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_core
// raw adc count to temperature by linear interpolation over a loaded table
//
// channel   direction  tdata                                        tuser
// s_axis    in         entry_index, entry_count, entry_temp,        op
//                      raw_count
// m_axis    out        temperature                                  out_of_range
//
// a table write gives no word
// a conversion makes one ram read per entry in the walk until an entry
// matches, then, unless the two bracketing entries have equal counts, a
// 28-step serial divide; a walk with no match at all ends at the last entry
// reset clears only control state; the table is undefined until written
// input is accepted only when the sequencer is idle; a finished word waits
// in the output register while the next input word is taken
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_core
    import tti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index, entry_count, entry_temp, raw_count
    input  logic [47:0] s_axis_tdata,
    // op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temperature, zero fill
    output logic [15:0] m_axis_tdata,
    // out_of_range
    output logic        m_axis_tuser
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRIME = 7'b0000010,
        ST_WALK  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [5:0]                in_index;
    logic [COUNT_W-1:0]        in_count;
    logic [TEMP_W-1:0]         in_temp;
    logic [COUNT_W-1:0]        in_raw;
    logic                      in_op;
    logic                      s_fire;

    logic                      wr_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]        rd_data;
    logic [COUNT_W-1:0]        rd_count;
    logic signed [TEMP_W-1:0]  rd_temp;

    logic [COUNT_W-1:0]        raw_reg;
    logic [COUNT_W-1:0]        raw_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [COUNT_W-1:0]        prev_count_reg;
    logic [COUNT_W-1:0]        prev_count_next;
    logic signed [TEMP_W-1:0]  prev_temp_reg;
    logic signed [TEMP_W-1:0]  prev_temp_next;
    logic signed [COUNT_W:0]   dx_reg;
    logic signed [COUNT_W:0]   dx_next;
    logic signed [TEMP_W:0]    dt_reg;
    logic signed [TEMP_W:0]    dt_next;
    logic signed [COUNT_W:0]   den_reg;
    logic signed [COUNT_W:0]   den_next;
    logic signed [TEMP_W-1:0]  t0_reg;
    logic signed [TEMP_W-1:0]  t0_next;
    logic signed [29:0]        prod_reg;
    logic signed [29:0]        prod_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic signed [TEMP_W-1:0]  res_temp_reg;
    logic signed [TEMP_W-1:0]  res_temp_next;
    logic                      res_oor_reg;
    logic                      res_oor_next;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [15:0]               m_data_reg;
    logic [15:0]               m_data_next;
    logic                      m_user_reg;
    logic                      m_user_next;

    logic                      out_free;
    logic                      match;
    logic [29:0]               prod_abs;
    logic [COUNT_W:0]          den_abs;
    logic signed [29:0]        q_signed;
    logic signed [29:0]        sum;
    logic                      sum_fits;
    logic signed [TEMP_W-1:0]  sum_sat;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    assign in_index = s_axis_tdata[5:0];
    assign in_count = s_axis_tdata[19:6];
    assign in_temp  = s_axis_tdata[33:20];
    assign in_raw   = s_axis_tdata[47:34];
    assign in_op    = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s_fire && (in_op == OP_WRITE) && (32'(in_index) < TABLE_ENTRIES);

    assign rd_count = rd_data[COUNT_W-1:0];
    assign rd_temp  = rd_data[ENTRY_W-1:COUNT_W];
    assign match    = raw_reg >= rd_count;

    always_comb
    begin
        case (state_reg)
            ST_PRIME: rd_addr = idx_reg;
            ST_WALK:  rd_addr = idx_reg + 1'b1;
            default:  rd_addr = '0;
        endcase
    end

    tti_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(in_index)),
        .wr_data ({in_temp, in_count}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign prod_abs = prod_reg[29] ? 30'(-prod_reg) : prod_reg;
    assign den_abs  = den_reg[COUNT_W] ? (COUNT_W+1)'(-den_reg) : den_reg;

    assign div_req.start    = (state_reg == ST_SIGN);
    assign div_req.dividend = prod_abs[NUM_W-1:0];
    assign div_req.divisor  = den_abs[DEN_W-1:0];

    tti_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q_signed = neg_reg ? -$signed({2'b00, div_rsp.quotient})
                              :  $signed({2'b00, div_rsp.quotient});
    assign sum      = $signed({{(30-TEMP_W){t0_reg[TEMP_W-1]}}, t0_reg}) + q_signed;
    assign sum_fits = (sum[29:TEMP_W-1] == '0) || (sum[29:TEMP_W-1] == '1);
    assign sum_sat  = sum_fits ? sum[TEMP_W-1:0] : (sum[29] ? TEMP_MIN : TEMP_MAX);

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        raw_next        = raw_reg;
        idx_next        = idx_reg;
        prev_count_next = prev_count_reg;
        prev_temp_next  = prev_temp_reg;
        dx_next         = dx_reg;
        dt_next         = dt_reg;
        den_next        = den_reg;
        t0_next         = t0_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        res_temp_next   = res_temp_reg;
        res_oor_next    = res_oor_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (in_op == OP_CONVERT))
                begin
                    raw_next   = in_raw;
                    idx_next   = IDX_W'(1);
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                prev_count_next = rd_count;
                prev_temp_next  = rd_temp;
                state_next      = ST_WALK;
            end
            ST_WALK:
            begin
                if (match)
                begin
                    dx_next    = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_count_reg});
                    dt_next    = $signed({rd_temp[TEMP_W-1], rd_temp})
                               - $signed({prev_temp_reg[TEMP_W-1], prev_temp_reg});
                    den_next   = $signed({1'b0, rd_count}) - $signed({1'b0, prev_count_reg});
                    t0_next    = prev_temp_reg;
                    state_next = ST_MUL;
                end
                else if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    res_temp_next = LOW_LIMIT_TEMP;
                    res_oor_next  = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    prev_count_next = rd_count;
                    prev_temp_next  = rd_temp;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next = dx_reg * dt_reg;
                if (den_reg == '0)
                begin
                    res_temp_next = t0_reg;
                    res_oor_next  = 1'b0;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                neg_next   = prod_reg[29] ^ den_reg[COUNT_W];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_temp_next = sum_sat;
                    res_oor_next  = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_temp_reg};
                    m_user_next  = res_oor_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg        <= raw_next;
        idx_reg        <= idx_next;
        prev_count_reg <= prev_count_next;
        prev_temp_reg  <= prev_temp_next;
        dx_reg         <= dx_next;
        dt_reg         <= dt_next;
        den_reg        <= den_next;
        t0_reg         <= t0_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_temp_reg   <= res_temp_next;
        res_oor_reg    <= res_oor_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ rtl/tti_ram.sv @@
// ----------------------------------------------------------------------------
// tti_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tti_divider.sv @@
// ----------------------------------------------------------------------------
// tti_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tti_divider
    import tti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     quo_next;
    logic [DEN_W-1:0]     divisor_reg;
    logic [DEN_W-1:0]     divisor_next;

    logic [DEN_W:0]       partial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign partial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = partial >= {1'b0, divisor_reg};
    assign diff    = partial - {1'b0, divisor_reg};

    always_comb
    begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            cnt_next     = DIV_CNT_W'(NUM_W);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
            rem_next  = ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
